// ----- design/tcce_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Text console character engine package
// Screen geometry, field widths, control characters and the command word
// that passes from the front end through the queue to the back end.
// ---------------------------------------------------------------------------
package tcce_pkg;

	localparam int COLUMNS  = 80;
	localparam int ROWS     = 25;
	localparam int TAB_STOP = 8;

	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 11;
	localparam int CELL_W = 16;

	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int TAB_W      = $clog2(TAB_STOP);
	localparam int ADDR_W     = ROW_W + COL_W;
	localparam int MEM_DEPTH  = 1 << ADDR_W;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	localparam int RECIP_K = IDX_W + COL_W;
	localparam int RECIP   = (1 << RECIP_K) / COLUMNS;
	localparam int PROD_W  = IDX_W + RECIP_K;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_FF    = 8'd12;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

	localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [2:0] {
		OP_PRINT,
		OP_LF,
		OP_BS,
		OP_TAB,
		OP_FF,
		OP_CR,
		OP_READ
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] ch;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic              in_range;
	} cmd_t;

endpackage
`default_nettype wire

// ----- design/tcce_in_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Text console input channel
// Valid/ready channel carrying one character or cell read request per word.
// ---------------------------------------------------------------------------
interface tcce_in_if;
	import tcce_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [CHAR_W-1:0] char_code;
	logic [IDX_W-1:0]  cell_index;

	modport source (output valid, output kind, output char_code, output cell_index,
		input ready);
	modport sink (input valid, input kind, input char_code, input cell_index,
		output ready);

endinterface
`default_nettype wire

// ----- design/tcce_out_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Text console result channel
// Valid/ready channel carrying the cursor position and read cell per word.
// ---------------------------------------------------------------------------
interface tcce_out_if;
	import tcce_pkg::*;

	logic              valid;
	logic              ready;
	logic [POS_W-1:0]  cursor_pos;
	logic [CELL_W-1:0] cell_value;

	modport source (output valid, output cursor_pos, output cell_value, input ready);
	modport sink (input valid, input cursor_pos, input cell_value, output ready);

endinterface
`default_nettype wire

// ----- design/tcce_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Text console front end
// Accepts input words, decodes control characters and splits a linear read
// address into row and column in a three-stage pipeline.
// ---------------------------------------------------------------------------
module tcce_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hold,
	tcce_in_if.sink       item,
	output logic          push,
	output tcce_pkg::cmd_t push_cmd,
	input  logic          full
);
	import tcce_pkg::*;

	function automatic op_t classify(input logic kind, input logic [CHAR_W-1:0] ch);
		op_t op;
		if (kind == KIND_READ) begin
			op = OP_READ;
		end else begin
			unique case (ch)
				CH_LF:   op = OP_LF;
				CH_BS:   op = OP_BS;
				CH_TAB:  op = OP_TAB;
				CH_FF:   op = OP_FF;
				CH_CR:   op = OP_CR;
				default: op = OP_PRINT;
			endcase
		end
		return op;
	endfunction

	logic v_s1, v_s2, v_s3;
	logic take1, take2, take3, load1;

	op_t               op_s1, op_s2;
	logic [CHAR_W-1:0] ch_s1, ch_s2;
	logic [IDX_W-1:0]  idx_s1, idx_s2;
	logic              hit_s1, hit_s2;
	logic [PROD_W-1:0] prod_s1;
	logic [IDX_W-1:0]  q_s2, qc_s2;
	cmd_t              cmd_s3;

	logic [IDX_W-1:0] quot;
	logic [IDX_W-1:0] rem;
	logic             fix;
	logic [IDX_W-1:0] row_full;
	logic [IDX_W-1:0] col_full;

	assign take3 = !v_s3 || !full;
	assign take2 = !v_s2 || take3;
	assign take1 = !v_s1 || take2;
	assign item.ready = take1 && !hold;
	assign load1 = item.valid && item.ready;
	assign push = v_s3 && !full;
	assign push_cmd = cmd_s3;

	assign quot = prod_s1[PROD_W-1:RECIP_K];
	assign rem = idx_s2 - qc_s2;
	assign fix = (rem >= IDX_W'(COLUMNS));
	assign row_full = fix ? q_s2 + 1'b1 : q_s2;
	assign col_full = fix ? rem - IDX_W'(COLUMNS) : rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (take1) begin
				v_s1 <= load1;
			end
			if (take2) begin
				v_s2 <= v_s1;
			end
			if (take3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			op_s1   <= classify(item.kind, item.char_code);
			ch_s1   <= item.char_code;
			idx_s1  <= item.cell_index;
			hit_s1  <= (int'(item.cell_index) < CELL_COUNT);
			prod_s1 <= PROD_W'(item.cell_index) * PROD_W'(RECIP);
		end
		if (v_s1 && take2) begin
			op_s2  <= op_s1;
			ch_s2  <= ch_s1;
			idx_s2 <= idx_s1;
			hit_s2 <= hit_s1;
			q_s2   <= quot;
			qc_s2  <= IDX_W'(quot * IDX_W'(COLUMNS));
		end
		if (v_s2 && take3) begin
			cmd_s3.op       <= op_s2;
			cmd_s3.ch       <= ch_s2;
			cmd_s3.row      <= row_full[ROW_W-1:0];
			cmd_s3.col      <= col_full[COL_W-1:0];
			cmd_s3.in_range <= hit_s2;
		end
	end

endmodule
`default_nettype wire

// ----- design/tcce_fifo.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Text console command queue
// Short first-in first-out buffer of decoded commands between the front
// end and the back end.
// ---------------------------------------------------------------------------
module tcce_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tcce_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output tcce_pkg::cmd_t head,
	output logic           empty
);
	import tcce_pkg::*;

	cmd_t                  slot_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("command queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= FIFO_DEPTH) else $error("command queue count out of range");

endmodule
`default_nettype wire

// ----- design/tcce_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Text console back end
// Owns the screen store, cursor and row rotation; executes one command at a
// time and presents its result word in an output register.
// ---------------------------------------------------------------------------
module tcce_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tcce_pkg::ATTR_W-1:0] cfg_wdata,
	input  tcce_pkg::cmd_t              head,
	input  logic                        empty,
	output logic                        pop,
	output logic                        init_busy,
	tcce_out_if.source                  result
);
	import tcce_pkg::*;

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_FILL, S_DONE} state_t;
	typedef enum logic [1:0] {FILL_LF, FILL_TAB, FILL_ROW} fill_t;

	localparam logic [COL_W-1:0] LAST_COL   = COL_W'(COLUMNS - 1);
	localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS - 1);
	localparam logic [TAB_W-1:0] LAST_PHASE = TAB_W'(TAB_STOP - 1);

	state_t            state_q;
	fill_t             fill_q;
	logic              init_q;
	logic [ATTR_W-1:0] attr_q;
	logic [ROW_W-1:0]  cur_row_q, cur_prow_q, top_q, clr_row_q;
	logic [COL_W-1:0]  cur_col_q, walk_col_q, clr_col_q;
	logic [TAB_W-1:0]  phase_q, walk_phase_q;
	logic              rd_hit_q;
	logic              out_valid_q;
	logic [POS_W-1:0]  pos_q;
	logic [CELL_W-1:0] value_q;
	logic [CELL_W-1:0] rdata_q;

	logic [CELL_W-1:0] mem [MEM_DEPTH];
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [CELL_W-1:0] mem_wdata;

	logic [ROW_W:0]   rd_sum;
	logic [ROW_W-1:0] rd_prow;
	logic [ROW_W-1:0] top_next, prow_next;
	logic             scroll;
	logic             fill_last;

	assign pop = (state_q == S_IDLE) && !empty;
	assign init_busy = init_q;

	assign rd_sum = {1'b0, head.row} + {1'b0, top_q};
	assign rd_prow = (int'(rd_sum) >= ROWS) ? ROW_W'(int'(rd_sum) - ROWS) : rd_sum[ROW_W-1:0];
	assign top_next = (top_q == LAST_ROW) ? '0 : top_q + 1'b1;
	assign prow_next = (cur_prow_q == LAST_ROW) ? '0 : cur_prow_q + 1'b1;
	assign scroll = (cur_row_q == LAST_ROW);
	assign fill_last = (walk_col_q == LAST_COL) ||
		(fill_q == FILL_TAB && walk_phase_q == LAST_PHASE);

	assign mem_re = pop && (head.op == OP_READ);
	assign mem_raddr = {rd_prow, head.col};

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {cur_prow_q, cur_col_q};
		mem_wdata = {attr_q, CH_SPACE};
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = {clr_row_q, clr_col_q};
				mem_wdata = {(init_q ? RESET_ATTR : attr_q), CH_SPACE};
			end
			S_IDLE: begin
				if (pop && head.op == OP_PRINT) begin
					mem_we    = 1'b1;
					mem_wdata = {attr_q, head.ch};
				end
			end
			S_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = {cur_prow_q, walk_col_q};
			end
			S_DONE: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	assign result.valid      = out_valid_q;
	assign result.cursor_pos = pos_q;
	assign result.cell_value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			fill_q       <= FILL_LF;
			init_q       <= 1'b1;
			attr_q       <= RESET_ATTR;
			cur_row_q    <= '0;
			cur_prow_q   <= '0;
			top_q        <= '0;
			clr_row_q    <= '0;
			cur_col_q    <= '0;
			walk_col_q   <= '0;
			clr_col_q    <= '0;
			phase_q      <= '0;
			walk_phase_q <= '0;
			rd_hit_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			pos_q        <= '0;
			value_q      <= '0;
		end else begin
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (clr_col_q == LAST_COL) begin
						clr_col_q <= '0;
						if (clr_row_q == LAST_ROW) begin
							clr_row_q  <= '0;
							top_q      <= '0;
							cur_row_q  <= '0;
							cur_prow_q <= '0;
							cur_col_q  <= '0;
							phase_q    <= '0;
							init_q     <= 1'b0;
							state_q    <= init_q ? S_IDLE : S_DONE;
						end else begin
							clr_row_q <= clr_row_q + 1'b1;
						end
					end else begin
						clr_col_q <= clr_col_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (pop) begin
						rd_hit_q <= 1'b0;
						unique case (head.op)
							OP_READ: begin
								rd_hit_q <= head.in_range;
								state_q  <= S_DONE;
							end
							OP_PRINT: begin
								if (cur_col_q == LAST_COL) begin
									cur_col_q <= '0;
									phase_q   <= '0;
									if (scroll) begin
										top_q      <= top_next;
										cur_prow_q <= top_q;
										walk_col_q <= '0;
										fill_q     <= FILL_ROW;
										state_q    <= S_FILL;
									end else begin
										cur_row_q  <= cur_row_q + 1'b1;
										cur_prow_q <= prow_next;
										state_q    <= S_DONE;
									end
								end else begin
									cur_col_q <= cur_col_q + 1'b1;
									phase_q   <= (phase_q == LAST_PHASE) ? '0 : phase_q + 1'b1;
									state_q   <= S_DONE;
								end
							end
							OP_LF: begin
								walk_col_q <= cur_col_q;
								fill_q     <= FILL_LF;
								state_q    <= S_FILL;
							end
							OP_TAB: begin
								walk_col_q   <= cur_col_q;
								walk_phase_q <= phase_q;
								fill_q       <= FILL_TAB;
								state_q      <= S_FILL;
							end
							OP_BS: begin
								if (cur_col_q != '0) begin
									cur_col_q <= cur_col_q - 1'b1;
									phase_q   <= (phase_q == '0) ? LAST_PHASE : phase_q - 1'b1;
								end
								state_q <= S_DONE;
							end
							OP_CR: begin
								cur_col_q <= '0;
								phase_q   <= '0;
								state_q   <= S_DONE;
							end
							OP_FF: begin
								clr_row_q <= '0;
								clr_col_q <= '0;
								state_q   <= S_CLEAR;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_FILL: begin
					if (!fill_last) begin
						walk_col_q   <= walk_col_q + 1'b1;
						walk_phase_q <= walk_phase_q + 1'b1;
					end else if (fill_q == FILL_ROW) begin
						state_q <= S_DONE;
					end else if (fill_q == FILL_TAB && walk_col_q != LAST_COL) begin
						cur_col_q <= walk_col_q + 1'b1;
						phase_q   <= '0;
						state_q   <= S_DONE;
					end else begin
						cur_col_q <= '0;
						phase_q   <= '0;
						if (scroll) begin
							top_q      <= top_next;
							cur_prow_q <= top_q;
							walk_col_q <= '0;
							fill_q     <= FILL_ROW;
						end else begin
							cur_row_q  <= cur_row_q + 1'b1;
							cur_prow_q <= prow_next;
							state_q    <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						pos_q       <= POS_W'(POS_W'(cur_row_q) * POS_W'(COLUMNS) +
							POS_W'(cur_col_q));
						value_q     <= rd_hit_q ? rdata_q : '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		int'(cur_col_q) < COLUMNS && int'(cur_row_q) < ROWS)
		else $error("cursor outside the screen");
	a_write_col: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> int'(mem_waddr[COL_W-1:0]) < COLUMNS)
		else $error("screen write beyond the last column");
	a_init_clear: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> (state_q == S_CLEAR && !pop))
		else $error("command taken during reset clearing pass");
	a_phase_home: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_col_q == '0) |-> (phase_q == '0))
		else $error("tab phase out of step with cursor column");

endmodule
`default_nettype wire

// ----- design/text_console_char_engine.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Text console character engine
// Character stream to text-mode screen store with cursor, control codes and
// scrolling; also serves single cell reads.
// ---------------------------------------------------------------------------
// Usage:
//   item   : one word per character (kind 0) or cell read (kind 1, cell_index).
//   result : one word per item, cursor_pos after the item and the read cell
//            (attribute in the high byte), 0 in cell_value for characters.
//   cfg_we/cfg_wdata set the attribute byte used for every cell written after the reset clearing pass.
// Timing: the front end takes a word every cycle, unless a full queue or the
// reset clearing pass holds it back, into a three-stage decode pipeline and a
// four-word command queue. The back end executes one command at a time; line
// feed and tab blank cells from the cursor onward; a scroll rotates the row
// map and blanks the new bottom row; form feed clears the whole screen and
// homes the cursor.
// Reset: a clearing pass writes every cell with a grey blank, with item.ready
// low; configuration writes are taken.
// Stall: the result register holds its word, the back end waits, the queue
// fills and item.ready drops.
// ---------------------------------------------------------------------------
module text_console_char_engine (
	input  logic                        clk,
	input  logic                        arst_n,
	tcce_in_if.sink                     item,
	tcce_out_if.source                  result,
	input  logic                        cfg_we,
	input  logic [tcce_pkg::ATTR_W-1:0] cfg_wdata
);
	import tcce_pkg::*;

	logic push, full, pop, empty, init_busy;
	cmd_t push_cmd, head;

	tcce_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.hold     (init_busy),
		.item     (item),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	tcce_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.head     (head),
		.empty    (empty)
	);

	tcce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.init_busy (init_busy),
		.result    (result)
	);

endmodule
`default_nettype wire
